[hdl/pghp_pkg.sv]
// Shared constants for the perceptron/gshare hybrid predictor.
`default_nettype none
package pghp_pkg;
  localparam logic       REQ_PREDICT  = 1'b0;
  localparam logic       REQ_UPDATE   = 1'b1;
  localparam logic [9:0] THRESH_RESET = 10'd46;
  localparam logic [9:0] MAG_MAX      = 10'd1023;
  localparam logic [1:0] COUNTER_MAX  = 2'd3;
  localparam logic [1:0] GSHARE_INIT  = 2'd2;
  localparam int         PC_BITS      = 32;
endpackage
`default_nettype wire

[hdl/pghp_ram.sv]
// Generic simple dual-address RAM with registered read.
`default_nettype none
module pghp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hdl/perceptron_gshare_hybrid_predictor_unit.sv]
// Top level: hybrid perceptron/gshare branch predictor with chooser.
// Each item passes through the reciprocal index-reduction steps (S_MOD), the index and base states,
// one weight access per weight plus one read lead (S_RUN), and one finish (S_FIN).
// A new item is taken only once the last one has finished; a waiting result holds the finish.
// Reset: synchronous active-low; a clearing pass over the chooser, gshare and weight tables
// runs before items are taken.
`default_nettype none
module perceptron_gshare_hybrid_predictor_unit #(
  parameter int HISTORY_BITS       = 17,
  parameter int PERCEPTRON_ENTRIES = 2048,
  parameter int GSHARE_ENTRIES     = 131072,
  parameter int CHOOSER_ENTRIES    = 16384,
  parameter int WEIGHT_BITS        = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [31:0] in_pc,
  input  wire logic        in_outcome_taken,
  input  wire logic        in_predicted_taken,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_prediction_taken,
  output logic             out_chose_gshare,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [9:0]  cfg_data
);
  import pghp_pkg::*;

  localparam int NW    = HISTORY_BITS + 1;
  localparam int WDEP  = PERCEPTRON_ENTRIES * NW;
  localparam int CA    = $clog2(CHOOSER_ENTRIES);
  localparam int GA    = $clog2(GSHARE_ENTRIES);
  localparam int PA    = $clog2(PERCEPTRON_ENTRIES);
  localparam int WA    = $clog2(WDEP);
  localparam int MAXCG = (CHOOSER_ENTRIES > GSHARE_ENTRIES) ? CHOOSER_ENTRIES : GSHARE_ENTRIES;
  localparam int MAXE  = (MAXCG > PERCEPTRON_ENTRIES) ? MAXCG : PERCEPTRON_ENTRIES;
  localparam int MAXD  = (MAXCG > WDEP) ? MAXCG : WDEP;
  localparam int RW    = $clog2(MAXE) + 1;
  localparam int CLW   = $clog2(MAXD) + 1;
  localparam int CW    = $clog2(NW + 1);
  localparam int HW    = $clog2(HISTORY_BITS);
  localparam int SW    = WEIGHT_BITS + $clog2(NW) + 1;
  localparam logic [RW-1:0] MOD_C = RW'(CHOOSER_ENTRIES);
  localparam logic [RW-1:0] MOD_G = RW'(GSHARE_ENTRIES);
  localparam logic [RW-1:0] MOD_P = RW'(PERCEPTRON_ENTRIES);
  localparam logic [31:0] RCP_C = 32'(64'h1_0000_0000 / 64'(CHOOSER_ENTRIES));
  localparam logic [31:0] RCP_G = 32'(64'h1_0000_0000 / 64'(GSHARE_ENTRIES));
  localparam logic [31:0] RCP_P = 32'(64'h1_0000_0000 / 64'(PERCEPTRON_ENTRIES));
  localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MOD, S_IDX, S_BASE, S_RUN, S_FIN
  } state_t;

  state_t                  state_r;
  logic [CLW-1:0]          clr_r;
  logic [2:0]              step_r;
  logic [31:0]             q_r;
  logic [CW-1:0]           cnt_r;
  logic                    upd_r, taken_r, pred_r, train_r;
  logic [31:0]             pc_r;
  logic [HISTORY_BITS-1:0] hist_r;
  logic [9:0]              thresh_r, last_mag_r;
  logic [RW-1:0]           pc_c_r, pc_g_r, pc_p_r, hs_c_r, hs_g_r, hs_p_r;
  logic [CA-1:0]           ci_r;
  logic [GA-1:0]           gi_r;
  logic [PA-1:0]           pi_r;
  logic [WA-1:0]           base_r;
  logic signed [SW-1:0]    sum_r;
  logic                    out_valid_r, out_pred_r, out_gs_r;

  function automatic logic [RW-1:0] wrap(input logic [RW-1:0] x, input logic [RW-1:0] m);
    logic [RW-1:0] t;
    t = x;
    if (t >= m) begin
      t = t - m;
    end
    return t;
  endfunction

  logic [31:0] hist32;
  assign hist32 = 32'(hist_r);

  // remainder by reciprocal: quotient estimate one step, multiply back and fix up the next
  logic [31:0] mx, rcp, mx_prev, mod_prev, rem_raw, rem_fix;
  logic [63:0] prod;

  always_comb begin
    mx = (step_r < 3'd3) ? pc_r : hist32;
    case (step_r)
      3'd0, 3'd3: rcp = RCP_C;
      3'd1, 3'd4: rcp = RCP_G;
      default:    rcp = RCP_P;
    endcase
    mx_prev = (step_r <= 3'd3) ? pc_r : hist32;
    case (step_r)
      3'd1, 3'd4: mod_prev = 32'(CHOOSER_ENTRIES);
      3'd2, 3'd5: mod_prev = 32'(GSHARE_ENTRIES);
      default:    mod_prev = 32'(PERCEPTRON_ENTRIES);
    endcase
    prod    = 64'(mx) * 64'(rcp);
    rem_raw = mx_prev - q_r * mod_prev;
    rem_fix = (rem_raw >= mod_prev) ? rem_raw - mod_prev : rem_raw;
  end

  // memory ports
  logic                          c_we, g_we, w_we;
  logic [CA-1:0]                 c_waddr;
  logic [GA-1:0]                 g_waddr;
  logic [WA-1:0]                 w_waddr, w_raddr;
  logic [1:0]                    c_wdata, g_wdata, c_rdata, g_rdata;
  logic [WEIGHT_BITS-1:0]        w_wdata, w_rdata;

  logic                          clearing;
  logic                          run_data;
  logic [CW-1:0]                 jdx;
  logic [HW-1:0]                 hidx;
  logic                          hbit, is_bias, up;
  logic signed [WEIGHT_BITS-1:0] w_cur, w_adj;
  logic [1:0]                    c_new, g_new;
  logic                          sel_g, correct, down;

  assign clearing = (state_r == S_CLEAR);
  assign run_data = (state_r == S_RUN) && (cnt_r != '0);
  assign jdx      = cnt_r - CW'(1);
  assign hidx     = HW'(cnt_r - CW'(2));
  assign is_bias  = (cnt_r == CW'(1));
  assign hbit     = hist_r[hidx];
  assign up       = is_bias ? taken_r : (taken_r == hbit);
  assign w_cur    = signed'(w_rdata);

  always_comb begin
    w_adj = w_cur;
    if (up && w_cur != W_MAX) begin
      w_adj = w_cur + WEIGHT_BITS'(1);
    end else if (!up && w_cur != W_MIN) begin
      w_adj = w_cur - WEIGHT_BITS'(1);
    end
  end

  assign sel_g   = c_rdata[1];
  assign correct = (taken_r == pred_r);
  assign down    = (!sel_g && correct) || (sel_g && !correct);

  always_comb begin
    c_new = c_rdata;
    if (down) begin
      if (c_rdata != 2'd0) c_new = c_rdata - 2'd1;
    end else begin
      if (c_rdata != COUNTER_MAX) c_new = c_rdata + 2'd1;
    end
    g_new = g_rdata;
    if (taken_r) begin
      if (g_rdata != COUNTER_MAX) g_new = g_rdata + 2'd1;
    end else begin
      if (g_rdata != 2'd0) g_new = g_rdata - 2'd1;
    end
  end

  always_comb begin
    c_we    = clearing ? (clr_r < CLW'(CHOOSER_ENTRIES)) : (upd_r && is_bias && run_data);
    c_waddr = clearing ? CA'(clr_r) : ci_r;
    c_wdata = clearing ? 2'd0 : c_new;
    g_we    = clearing ? (clr_r < CLW'(GSHARE_ENTRIES)) : (upd_r && is_bias && run_data);
    g_waddr = clearing ? GA'(clr_r) : gi_r;
    g_wdata = clearing ? GSHARE_INIT : g_new;
    w_we    = clearing ? (clr_r < CLW'(WDEP)) : (upd_r && train_r && run_data);
    w_waddr = clearing ? WA'(clr_r) : (base_r + WA'(jdx));
    w_wdata = clearing ? '0 : w_adj;
    w_raddr = base_r + WA'(cnt_r);
  end

  pghp_ram #(.WIDTH(2), .DEPTH(CHOOSER_ENTRIES)) u_chooser (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(ci_r), .rdata(c_rdata)
  );
  pghp_ram #(.WIDTH(2), .DEPTH(GSHARE_ENTRIES)) u_gshare (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata), .raddr(gi_r), .rdata(g_rdata)
  );
  pghp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(WDEP)) u_weights (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr), .rdata(w_rdata)
  );

  // finishing values
  logic signed [SW-1:0] w_ext, abs_s;
  logic [31:0]          mag_w;
  logic [9:0]           mag_nxt;
  logic                 g_pred, p_pred, out_free;
  assign w_ext    = SW'(w_cur);
  assign abs_s    = sum_r[SW-1] ? -sum_r : sum_r;
  assign mag_w    = 32'(unsigned'(abs_s));
  assign mag_nxt  = (mag_w > 32'(MAG_MAX)) ? MAG_MAX : mag_w[9:0];
  assign g_pred   = g_rdata[1];
  assign p_pred   = !sum_r[SW-1];
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      hist_r      <= '0;
      thresh_r    <= THRESH_RESET;
      last_mag_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        thresh_r <= cfg_data;
      end
      // the finish state owns the valid flag when it is there
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + CLW'(1);
          if (clr_r == CLW'(MAXD - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            upd_r   <= (in_req_type == REQ_UPDATE);
            pc_r    <= in_pc;
            taken_r <= in_outcome_taken;
            pred_r  <= in_predicted_taken;
            step_r  <= '0;
            state_r <= S_MOD;
          end
        end
        S_MOD: begin
          q_r <= prod[63:32];
          case (step_r)
            3'd1:    pc_c_r <= RW'(rem_fix);
            3'd2:    pc_g_r <= RW'(rem_fix);
            3'd3:    pc_p_r <= RW'(rem_fix);
            3'd4:    hs_c_r <= RW'(rem_fix);
            3'd5:    hs_g_r <= RW'(rem_fix);
            3'd6:    hs_p_r <= RW'(rem_fix);
            default: ;
          endcase
          step_r <= step_r + 3'd1;
          if (step_r == 3'd6) state_r <= S_IDX;
        end
        S_IDX: begin
          ci_r    <= CA'(wrap(pc_c_r ^ hs_c_r, MOD_C));
          gi_r    <= GA'(wrap(pc_g_r ^ hs_g_r, MOD_G));
          pi_r    <= PA'(wrap(pc_p_r ^ hs_p_r, MOD_P));
          train_r <= (taken_r != pred_r) || (last_mag_r <= thresh_r);
          state_r <= S_BASE;
        end
        S_BASE: begin
          base_r  <= WA'(pi_r * NW);
          sum_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_RUN;
        end
        S_RUN: begin
          // weight for cnt-1 arrives while the read for cnt goes out
          if (cnt_r != '0) begin
            sum_r <= (is_bias || hbit) ? sum_r + w_ext : sum_r - w_ext;
          end
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(NW)) state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (upd_r) begin
              out_pred_r <= 1'b0;
              out_gs_r   <= 1'b0;
              hist_r     <= {hist_r[HISTORY_BITS-2:0], taken_r};
            end else begin
              out_pred_r <= sel_g ? g_pred : p_pred;
              out_gs_r   <= sel_g;
              last_mag_r <= mag_nxt;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall             = (state_r != S_IDLE);
  assign cfg_ready            = 1'b1;
  assign out_valid            = out_valid_r;
  assign out_prediction_taken = out_pred_r;
  assign out_chose_gshare     = out_gs_r;
endmodule
`default_nettype wire
